// File: rtl/atan2_pkg.sv
// Package for the fixed-point atan2 block: constants and stage types.
// No dependencies.
`default_nettype none
package atan2_pkg;
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 12;
  localparam int ZW                  = 31;          // Q30 ratio, holds 2^30
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [9:0]  COEF_NUM   = 10'd287;
  typedef enum logic [1:0] {
    CASE_XZERO = 2'd0,
    CASE_YLT   = 2'd1,
    CASE_YGE   = 2'd2
  } case_t;
  typedef struct packed {
    logic  x_neg;
    logic  y_neg;
    logic  y_zero;
    logic  same;
    case_t kind;
  } ctl_t;
endpackage
`default_nettype wire

// File: rtl/atan2_div_cell.sv
// One restoring-division cell: one quotient bit per cycle while en is high, registered.
// Depends on atan2_pkg.
`default_nettype none
module atan2_div_cell #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int QW = 31,
  parameter int TW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          v_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [QW-1:0] q_i,
  input  wire logic [TW-1:0] tag_i,
  output logic               v_o,
  output logic [DW-1:0]      rem_o,
  output logic [NW-1:0]      num_o,
  output logic [DW-1:0]      den_o,
  output logic [QW-1:0]      q_o,
  output logic [TW-1:0]      tag_o
);
  import atan2_pkg::*;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  always_comb begin
    trial   = {rem_i, num_i[NW-1]};
    diff    = trial - {1'b0, den_i};
    ge      = !diff[DW];
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end
  logic v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      num_o <= {num_i[NW-2:0], 1'b0};
      den_o <= den_i;
      q_o   <= {q_i[QW-2:0], ge};
      tag_o <= tag_i;
    end
  end
  assign v_o = v_r;
endmodule
`default_nettype wire

// File: rtl/atan2_divider.sv
// Pipelined divider: a chain of division cells, one quotient bit per cell.
// Depends on atan2_pkg and atan2_div_cell.
`default_nettype none
module atan2_divider #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int QW = 31,
  parameter int TW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          v_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [TW-1:0] tag_i,
  output logic               v_o,
  output logic [QW-1:0]      q_o,
  output logic [DW-1:0]      rem_o,
  output logic [TW-1:0]      tag_o
);
  import atan2_pkg::*;
  // numerator bits above the last QW preload the remainder
  logic          v   [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [NW-1:0] num [QW+1];
  logic [DW-1:0] den [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [TW-1:0] tag [QW+1];
  assign v[0]   = v_i;
  assign rem[0] = DW'(num_i >> QW);
  assign num[0] = num_i << (NW - QW);
  assign den[0] = den_i;
  assign q[0]   = '0;
  assign tag[0] = tag_i;
  for (genvar i = 0; i < QW; i++) begin : g_cell
    atan2_div_cell #(.NW(NW), .DW(DW), .QW(QW), .TW(TW)) u_cell (
      .clk, .rst_n, .en,
      .v_i(v[i]), .rem_i(rem[i]), .num_i(num[i]), .den_i(den[i]),
      .q_i(q[i]), .tag_i(tag[i]),
      .v_o(v[i+1]), .rem_o(rem[i+1]), .num_o(num[i+1]), .den_o(den[i+1]),
      .q_o(q[i+1]), .tag_o(tag[i+1])
    );
  end
  assign v_o   = v[QW];
  assign q_o   = q[QW];
  assign rem_o = rem[QW];
  assign tag_o = tag[QW];
endmodule
`default_nettype wire

// File: rtl/atan2_rational_approx.sv
// Fixed-point atan2(y,x) by atan(z) = z/(1+0.28 z^2), one request per cycle.
// Pipeline: input register, ratio divider cells, square/scale/sum stages, final
// divider cells, output register.
// Throughput one request per cycle while en is high: each cell takes a new one.
// The whole pipe halts while the output register is full and stalled.
// Synchronous active-low reset clears all valid flags; payloads are not reset.
`default_nettype none
module atan2_rational_approx #(
  parameter int COORD_WIDTH     = atan2_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = atan2_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]  in_y_coord,
  input  wire logic signed [COORD_WIDTH-1:0]  in_x_coord,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [ANGLE_FRAC_BITS+2:0]   out_angle
);
  import atan2_pkg::*;
  localparam int AW  = ANGLE_FRAC_BITS + 3;
  localparam int MW  = COORD_WIDTH + 1;               // magnitude width
  localparam int TW  = $bits(ctl_t);
  localparam int N1  = MW + 30;                       // s << 30
  localparam int D2W = 32;                            // d < 2^31.3
  localparam int N2  = ZW + ANGLE_FRAC_BITS + 1;      // z<<F + d/2 width
  localparam int Q2  = ANGLE_FRAC_BITS + 2;           // t <= 2^F
  localparam logic [AW-1:0] PI_A =
    AW'((PI_Q30 + (32'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));
  localparam logic [AW-1:0] HPI_A =
    AW'((PI_Q30 + (32'd1 << (30 - ANGLE_FRAC_BITS))) >> (31 - ANGLE_FRAC_BITS));

  // global advance: pipe moves whenever the output slot is free or taken
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---- stage A: magnitudes, ordering and case decode ----
  logic          a_v_r;
  logic [MW-1:0] a_s_r, a_g_r;
  ctl_t          a_c_r;
  logic [MW-1:0] ya, xa;
  ctl_t          c_nxt;
  always_comb begin
    ya = in_y_coord[COORD_WIDTH-1] ? MW'(-{in_y_coord[COORD_WIDTH-1], in_y_coord})
                                   : MW'({1'b0, in_y_coord});
    xa = in_x_coord[COORD_WIDTH-1] ? MW'(-{in_x_coord[COORD_WIDTH-1], in_x_coord})
                                   : MW'({1'b0, in_x_coord});
    c_nxt.x_neg  = in_x_coord[COORD_WIDTH-1];
    c_nxt.y_neg  = in_y_coord[COORD_WIDTH-1];
    c_nxt.y_zero = (in_y_coord == '0);
    c_nxt.same   = (in_x_coord[COORD_WIDTH-1] == in_y_coord[COORD_WIDTH-1]);
    if (in_x_coord == '0) begin
      c_nxt.kind = CASE_XZERO;
    end else if (ya < xa) begin
      c_nxt.kind = CASE_YLT;
    end else begin
      c_nxt.kind = CASE_YGE;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r <= c_nxt;
      a_s_r <= (ya < xa) ? ya : xa;
      a_g_r <= (ya < xa) ? xa : ya;
    end
  end

  // ---- ratio z = floor(s*2^30/g), Q30 ----
  // x==0 gives g possibly 0 only when y==0 too; result is discarded then
  logic          z_v;
  logic [ZW-1:0] z_q;
  logic [MW-1:0] z_rem;
  logic [TW-1:0] z_tag;
  atan2_divider #(.NW(N1), .DW(MW), .QW(ZW), .TW(TW)) u_div_z (
    .clk, .rst_n, .en,
    .v_i(a_v_r), .num_i(N1'({a_s_r, 30'd0})),
    .den_i((a_g_r == '0) ? MW'(1) : a_g_r), .tag_i(a_c_r),
    .v_o(z_v), .q_o(z_q), .rem_o(z_rem), .tag_o(z_tag)
  );

  // ---- z^2, then d, then the second dividend ----
  logic          m_v_r, k_v_r, e_v_r;
  logic [ZW-1:0] m_z_r, k_z_r, e_z_r;
  logic [61:0]   m_sq_r;
  logic [40:0]   k_p_r;
  logic [D2W-1:0] e_d_r;
  ctl_t          m_c_r, k_c_r, e_c_r;
  logic [31:0]   z2;
  assign z2 = 32'(m_sq_r >> 30);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      k_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= z_v;
      k_v_r <= m_v_r;
      e_v_r <= k_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_z_r  <= z_q;
      m_c_r  <= ctl_t'(z_tag);
      m_sq_r <= 62'(z_q) * 62'(z_q);
      k_z_r  <= m_z_r;
      k_c_r  <= m_c_r;
      k_p_r  <= 41'(z2) * 41'(COEF_NUM);
      e_z_r  <= k_z_r;
      e_c_r  <= k_c_r;
      e_d_r  <= D2W'(32'd1 << 30) + D2W'(k_p_r >> 10);
    end
  end

  // ---- t = round(z*2^F / d) ----
  logic          t_v;
  logic [Q2-1:0] t_q;
  logic [D2W-1:0] t_rem;
  logic [TW-1:0] t_tag;
  atan2_divider #(.NW(N2), .DW(D2W), .QW(Q2), .TW(TW)) u_div_t (
    .clk, .rst_n, .en,
    .v_i(e_v_r),
    .num_i(N2'({e_z_r, {ANGLE_FRAC_BITS{1'b0}}}) + N2'(e_d_r >> 1)),
    .den_i(e_d_r), .tag_i(e_c_r),
    .v_o(t_v), .q_o(t_q), .rem_o(t_rem), .tag_o(t_tag)
  );

  // ---- quadrant fix-up into the output register ----
  ctl_t          fc;
  logic [AW-1:0] ts, r;
  always_comb begin
    fc = ctl_t'(t_tag);
    ts = fc.same ? AW'(t_q) : AW'(-AW'(t_q));
    case (fc.kind)
      CASE_XZERO: r = fc.y_zero ? '0 : (fc.y_neg ? AW'(-HPI_A) : HPI_A);
      CASE_YLT: begin
        r = ts;
        if (fc.x_neg) begin
          r = fc.y_neg ? AW'(ts - PI_A) : AW'(ts + PI_A);
        end
      end
      CASE_YGE: begin
        r = AW'(HPI_A - ts);
        if (fc.y_neg) begin
          r = AW'(r - PI_A);
        end
      end
      default: r = '0;
    endcase
  end
  logic          o_v_r;
  logic [AW-1:0] o_a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= t_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_a_r <= r;
    end
  end
  assign out_valid = o_v_r;
  assign out_angle = o_a_r;

  // remainders are not needed
  logic unused_rem;
  assign unused_rem = ^{z_rem, t_rem};
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Testbench for atan2_rational_approx: drives y,x vectors and checks angles.
// Holds its own fixed-point angle predictor; depends on the block's ports only.
`timescale 1ns / 1ps
module tb_top;
  localparam int CW = 16;
  localparam int FB = 12;
  localparam int AW = FB + 3;
  localparam int LATENCY = 80;
  localparam int WATCH_LIMIT = 4000;

  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } vec_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_y_coord;
  logic signed [CW-1:0] in_x_coord;
  logic out_valid;
  logic out_stall;
  logic signed [AW-1:0] out_angle;

  atan2_rational_approx i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_y_coord(in_y_coord), .in_x_coord(in_x_coord),
    .out_valid(out_valid), .out_stall(out_stall), .out_angle(out_angle)
  );

  vec_t pending_vecs[$];
  logic [AW-1:0] expected_angles[$];
  int errors = 0;
  int watch = 0;
  bit quiet_tail = 0;       // no idling in the last part of the run
  int hold_off = 0;         // long receiver stall, counted in the monitor
  bit sender_pause = 0;
  int in_gap = 0;           // remaining sender idle cycles in a burst
  int out_gap = 0;          // remaining receiver stall cycles in a burst

  localparam longint PI_Q30 = 64'd3373259426;
  localparam longint A_PI = (PI_Q30 + (64'd1 << (29 - FB))) >> (30 - FB);
  localparam longint A_HPI = (PI_Q30 + (64'd1 << (30 - FB))) >> (31 - FB);

  // atan(s/g) in Q(FB), 0 <= s <= g, g > 0
  function automatic longint ratio_atan(longint s, longint g);
    longint z, z2, d;
    z = (s <<< 30) / g;
    z2 = (z * z) >>> 30;
    d = (64'd1 << 30) + ((287 * z2) >>> 10);
    return ((z <<< FB) + (d >>> 1)) / d;
  endfunction

  function automatic logic [AW-1:0] predict_angle(vec_t v);
    longint y, x, a, b, t, r;
    bit same;
    y = v.y;
    x = v.x;
    a = (y < 0) ? -y : y;
    b = (x < 0) ? -x : x;
    same = (x < 0) == (y < 0);
    if (x == 0) begin
      r = (y > 0) ? A_HPI : (y == 0) ? 0 : -A_HPI;
    end else if (a < b) begin
      t = ratio_atan(a, b);
      r = same ? t : -t;
      if (x < 0) r = (y < 0) ? r - A_PI : r + A_PI;
    end else begin
      t = ratio_atan(b, a);
      r = A_HPI - (same ? t : -t);
      if (y < 0) r = r - A_PI;
    end
    return r[AW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 15) - 8);       // tiny magnitudes
      1: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return CW'($urandom);
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Stimulus: directed corners, equal-magnitude cases, then random vectors.
  initial begin
    vec_t v;
    logic signed [CW-1:0] c[5];
    c = '{16'sh7fff, 16'sh8000, 0, 1, -1};
    foreach (c[i]) foreach (c[j]) begin
      v.y = c[i];
      v.x = c[j];
      pending_vecs.push_back(v);
    end
    // equal magnitudes and near-equal on each side
    v.y = 1000; v.x = -1000; pending_vecs.push_back(v);
    v.y = 999;  v.x = -1000; pending_vecs.push_back(v);
    v.y = -1001; v.x = 1000; pending_vecs.push_back(v);
    for (int n = 0; n < 650; n++) begin
      v.y = rand_coord();
      v.x = rand_coord();
      if ($urandom_range(0, 9) == 0) v.y = ($urandom_range(0, 1)) ? v.x : -v.x;
      pending_vecs.push_back(v);
    end
  end

  // Driver: offers the next request; holds payload while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_y_coord <= '0;
      in_x_coord <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_angles.push_back(predict_angle({in_y_coord, in_x_coord}));
      if (in_gap > 0 && !quiet_tail) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_vecs.size() != 0 && !sender_pause &&
          (quiet_tail || $urandom_range(0, 4) != 0)) begin
        in_valid <= 1'b1;
        {in_y_coord, in_x_coord} <= pending_vecs.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_gap <= quiet_tail ? 0 : $urandom_range(0, 2);
      end
    end
  end

  // Monitor: checks each accepted angle against the oldest expectation and drives out_stall.
  always @(posedge clk) begin
    logic [AW-1:0] exp_angle;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected angle %0d", out_angle);
          errors++;
        end else begin
          exp_angle = expected_angles.pop_front();
          if (out_angle !== exp_angle) begin
            $error("angle: expected %0d actual %0d", $signed(exp_angle), out_angle);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0 && !quiet_tail) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && ($urandom_range(0, 4) == 0)) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WATCH_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // long receiver hold-off while the sender keeps offering: fills the pipe
    wait (pending_vecs.size() < 600);
    @(posedge clk);
    hold_off <= 200;
    // sender pause until the pipe drains
    wait (pending_vecs.size() < 400);
    @(posedge clk);
    sender_pause <= 1;
    wait (expected_angles.size() == 0 && !in_valid);
    repeat (LATENCY) @(posedge clk);
    wait (expected_angles.size() == 0);
    sender_pause <= 0;
    wait (pending_vecs.size() < 120);
    quiet_tail <= 1;
    wait (pending_vecs.size() == 0);
    @(posedge clk);
    wait (!in_valid || !in_stall);
    @(posedge clk);
    wait (expected_angles.size() == 0);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/atan2_pkg.sv
rtl/atan2_div_cell.sv
rtl/atan2_divider.sv
rtl/atan2_rational_approx.sv
bench/tb_top.sv
